@@ design/alpm_pkg.sv @@
// ----------------------------------------------------------------------------
// alpm_pkg
// Shared widths, constants and register codes of the audio level peak meter.
// ----------------------------------------------------------------------------
package alpm_pkg;

  // Field widths
  localparam int SampleW  = 10;
  localparam int LevelW   = 8;
  localparam int NoiseW   = 10;
  localparam int CountW   = 8;
  localparam int QuotW    = 10;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 10;

  // Register reset values
  localparam logic [NoiseW-1:0] NoiseReset = 10'd10;
  localparam logic [CountW-1:0] CountReset = 8'd32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgNoise = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCount = 1'b1;

  // Meter constants
  localparam int BeatMargin = 30;
  localparam int HueStep    = 32;
  localparam int HoldFrames = 5;
  localparam int HoldMax    = 7;
  localparam int DecayStep  = 3;
  localparam int LevelMax   = 512;

endpackage

@@ design/alpm_serial_div.sv @@
// ----------------------------------------------------------------------------
// alpm_serial_div
// Restoring divider of the window total by WINDOW_SIZE, one quotient bit
// per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module alpm_serial_div #(
  parameter int WINDOW_SIZE = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic [$clog2(1023*WINDOW_SIZE+1)-1:0]         dividend_i,
  output logic [alpm_pkg::QuotW-1:0]                    quotient_o,
  output logic                                          done_o
);
  import alpm_pkg::*;

  localparam int RemW = $clog2(WINDOW_SIZE+1) + QuotW;
  localparam int CntW = $clog2(QuotW);

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [RemW-1:0]     dvs_q;
  logic [QuotW-1:0]    quo_q;
  logic                fits;

  // Compare and subtract the shifted divisor
  assign fits  = (rem_q >= dvs_q);
  assign rem_d = fits ? (rem_q - dvs_q) : rem_q;

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QuotW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the quotient in, shift the divisor down
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RemW'(dividend_i);
      dvs_q <= RemW'(WINDOW_SIZE) << (QuotW - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvs_q <= dvs_q >> 1;
      quo_q <= {quo_q[QuotW-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

@@ design/audio_level_peak_meter_top.sv @@
// ----------------------------------------------------------------------------
// audio_level_peak_meter_top
// Audio level meter with window mean, peak hold, beat hue and LED scaling.
// ----------------------------------------------------------------------------
// One request is one ADC sample; it yields one result. From acceptance until the
// next sample can be accepted, provided the result register is free, a sample
// passes these steps: accept it and read the oldest ring entry, update the
// running total, run the bit-serial mean divider (one quotient bit per cycle for
// ten bits, plus its done flag), update the level, peak and hue, run the
// bit-serial multipliers for the bar length and peak marker, and scale and load
// the result register. The result register lets the next sample enter while a
// result waits. The ring reads as zero until it has wrapped once, so no clearing
// pass follows reset.
// ----------------------------------------------------------------------------
module audio_level_peak_meter_top #(
  parameter int WINDOW_SIZE = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Sample channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [alpm_pkg::SampleW-1:0]    sample_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [alpm_pkg::LevelW-1:0]     audio_level_o,
  output logic [alpm_pkg::LevelW-1:0]     peak_level_o,
  output logic [alpm_pkg::LevelW-1:0]     lit_count_o,
  output logic [alpm_pkg::LevelW-1:0]     peak_led_o,
  output logic [alpm_pkg::LevelW-1:0]     beat_hue_o,
  // Register write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [alpm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [alpm_pkg::CfgDataW-1:0]   cfg_data_i
);
  import alpm_pkg::*;

  localparam int PosW  = $clog2(WINDOW_SIZE);
  localparam int TotW  = $clog2(1023*WINDOW_SIZE+1);
  localparam int ProdW = 2 * LevelW;
  localparam int MulCntW = $clog2(LevelW);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoad  = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StLevel = 3'd3;
  localparam logic [2:0] StMul   = 3'd4;
  localparam logic [2:0] StFin   = 3'd5;

  logic [2:0]           state_q, state_d;
  logic                 in_acc, out_load;

  // Registers and state
  logic [NoiseW-1:0]    noise_q;
  logic [CountW-1:0]    count_q;
  logic [PosW-1:0]      pos_q;
  logic                 wrapped_q;
  logic [TotW-1:0]      total_q, total_d;
  logic [LevelW-1:0]    peak_q, peak_d;
  logic [2:0]           hold_q, hold_d;
  logic [LevelW-1:0]    hue_q, hue_d;

  // Working registers
  logic [SampleW-1:0]   ring_mem_q [WINDOW_SIZE];
  logic [SampleW-1:0]   sample_q;
  logic [SampleW-1:0]   rd_q;
  logic [LevelW-1:0]    audio_q;
  logic [LevelW-1:0]    mul_a_q, mul_p_q;
  logic [ProdW-1:0]     acc_lit_q, acc_mark_q;
  logic [MulCntW-1:0]   mul_cnt_q;
  logic                 out_valid_q;
  logic [LevelW-1:0]    out_audio_q, out_peak_q, out_lit_q, out_mark_q, out_hue_q;

  // Divider hookup
  logic                 div_start;
  logic [QuotW-1:0]     mean;
  logic                 div_done;

  // Combinational datapath
  logic [SampleW-1:0]   old_smp, dev, lvl_raw, lvl;
  logic [17:0]          scaled;
  logic [LevelW-1:0]    audio_c, peak_dec, span;
  logic [2:0]           hold_inc;
  logic                 beat;
  logic [ProdW:0]       lit_sum, mark_sum;

  assign in_acc      = in_valid_i && (state_q == StIdle);
  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == StFin) && (!out_valid_q || !out_stall_i);
  assign div_start   = (state_q == StLoad);

  // Sample ring: write the new sample, read the one it replaces
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ring_mem_q[pos_q] <= sample_i;
      rd_q              <= ring_mem_q[pos_q];
    end
  end

  // Running total update
  assign old_smp = wrapped_q ? rd_q : '0;
  assign total_d = total_q - TotW'(old_smp) + TotW'(sample_q);

  alpm_serial_div #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_d),
    .quotient_o (mean),
    .done_o     (div_done)
  );

  // Level, beat and peak hold
  always_comb begin
    dev      = (sample_q >= mean) ? (sample_q - mean) : (mean - sample_q);
    lvl_raw  = (dev > noise_q) ? (dev - noise_q) : '0;
    lvl      = (lvl_raw > SampleW'(LevelMax)) ? SampleW'(LevelMax) : lvl_raw;
    scaled   = {lvl, 8'b0} - 18'(lvl);
    audio_c  = scaled[16:9];
    beat     = ({1'b0, audio_c} > ({1'b0, peak_q} + 9'(BeatMargin)));
    hold_inc = (hold_q == 3'(HoldMax)) ? hold_q : hold_q + 3'd1;
    peak_dec = (peak_q > LevelW'(DecayStep)) ? (peak_q - LevelW'(DecayStep)) : '0;
    hue_d    = beat ? (hue_q + LevelW'(HueStep)) : hue_q;
    if (audio_c > peak_q) begin
      peak_d = audio_c;
      hold_d = '0;
    end else begin
      hold_d = hold_inc;
      peak_d = (hold_inc > 3'(HoldFrames)) ? peak_dec : peak_q;
    end
  end

  // Divide the products by 255 exactly over their range
  assign span     = (count_q == '0) ? '0 : count_q - 1'b1;
  assign lit_sum  = (ProdW+1)'(acc_lit_q) + (ProdW+1)'(acc_lit_q[ProdW-1:LevelW]) + 1'b1;
  assign mark_sum = (ProdW+1)'(acc_mark_q) + (ProdW+1)'(acc_mark_q[ProdW-1:LevelW]) + 1'b1;

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_acc) state_d = StLoad;
      StLoad:  state_d = StDiv;
      StDiv:   if (div_done) state_d = StLevel;
      StLevel: state_d = StMul;
      StMul:   if (mul_cnt_q == '0) state_d = StFin;
      StFin:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control state and meter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      noise_q     <= NoiseReset;
      count_q     <= CountReset;
      pos_q       <= '0;
      wrapped_q   <= 1'b0;
      total_q     <= '0;
      peak_q      <= '0;
      hold_q      <= '0;
      hue_q       <= '0;
      mul_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgNoise: noise_q <= cfg_data_i[NoiseW-1:0];
          CfgCount: count_q <= cfg_data_i[CountW-1:0];
          default:  ;
        endcase
      end
      if (state_q == StLoad) begin
        total_q <= total_d;
        if (pos_q == PosW'(WINDOW_SIZE - 1)) begin
          pos_q     <= '0;
          wrapped_q <= 1'b1;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      if (state_q == StLevel) begin
        peak_q    <= peak_d;
        hold_q    <= hold_d;
        hue_q     <= hue_d;
        mul_cnt_q <= MulCntW'(LevelW - 1);
      end else if (state_q == StMul) begin
        mul_cnt_q <= mul_cnt_q - 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: capture, shift-add multiply, load result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
    end
    if (state_q == StLevel) begin
      audio_q    <= audio_c;
      mul_a_q    <= audio_c;
      mul_p_q    <= peak_d;
      acc_lit_q  <= '0;
      acc_mark_q <= '0;
    end else if (state_q == StMul) begin
      mul_a_q    <= {mul_a_q[LevelW-2:0], 1'b0};
      mul_p_q    <= {mul_p_q[LevelW-2:0], 1'b0};
      acc_lit_q  <= {acc_lit_q[ProdW-2:0], 1'b0} +
                    (mul_a_q[LevelW-1] ? ProdW'(count_q) : '0);
      acc_mark_q <= {acc_mark_q[ProdW-2:0], 1'b0} +
                    (mul_p_q[LevelW-1] ? ProdW'(span) : '0);
    end
    if (out_load) begin
      out_audio_q <= audio_q;
      out_peak_q  <= peak_q;
      out_lit_q   <= lit_sum[ProdW-1:LevelW];
      out_mark_q  <= mark_sum[ProdW-1:LevelW];
      out_hue_q   <= hue_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign audio_level_o = out_audio_q;
  assign peak_level_o  = out_peak_q;
  assign lit_count_o   = out_lit_q;
  assign peak_led_o    = out_mark_q;
  assign beat_hue_o    = out_hue_q;

endmodule

@@ design/alpm_checker.sv @@
// ----------------------------------------------------------------------------
// alpm_checker
// Port-level checks of the audio level peak meter, bound to the top level.
// ----------------------------------------------------------------------------
module alpm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [alpm_pkg::LevelW-1:0]     audio_level_o,
  input logic [alpm_pkg::LevelW-1:0]     peak_level_o,
  input logic [alpm_pkg::LevelW-1:0]     lit_count_o,
  input logic [alpm_pkg::LevelW-1:0]     peak_led_o,
  input logic [alpm_pkg::LevelW-1:0]     beat_hue_o
);
  import alpm_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(audio_level_o))
    else $error("stalled result dropped or changed");

  // Block the sample channel right after a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sample channel open right after a request");

  // Hue only moves in steps of 32
  a_hue_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> beat_hue_o[4:0] == 5'd0)
    else $error("beat hue off its step grid");

  // Silent level lights nothing, and the marker never reads 255
  a_bar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> peak_led_o != 8'd255 &&
                    (audio_level_o != 8'd0 || lit_count_o == 8'd0))
    else $error("bar or marker out of range");

  // Peak never more than one decay step below the level that produced it
  a_peak_near_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, peak_level_o} + 9'(DecayStep)) >= {1'b0, audio_level_o})
    else $error("held peak too far below current level");

endmodule

bind audio_level_peak_meter_top alpm_checker u_alpm_checker (.*);

@@ tb/sv/tb_audio_level_peak_meter_top.sv @@
// ----------------------------------------------------------------------------
// tb_audio_level_peak_meter_top
// Self-checking bench for the audio level meter: window mean, peak hold,
// beat hue and LED scaling.
// A tracker object mirrors the meter state and queues one expected reading per
// accepted sample request. Every result is compared against the oldest queued
// reading. Stimulus is a short directed run, followed by phases of random
// samples under different register settings. The sender works in bursts and
// the receiver stalls on its own schedule.
// ----------------------------------------------------------------------------
module tb_audio_level_peak_meter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import alpm_pkg::*;

  localparam int Window      = 16;
  localparam int ScaleMax    = 255;
  localparam int CycleLimit  = 400000;
  localparam int SettleWait  = 40;
  localparam int PhaseItems  = 155;
  localparam int NumPhases   = 8;
  localparam int NumDirected = 22;
  localparam int ReportMax   = 10;

  // Extremes, alternating bit patterns, a steady run to exercise hold and decay, then extremes
  localparam logic [SampleW-1:0] DirectedSamples [NumDirected] = '{
    10'd0, 10'd1023, 10'd0, 10'd1023, 10'h2AA, 10'h155, 10'd1023, 10'd1023,
    10'd600, 10'd600, 10'd600, 10'd600, 10'd600, 10'd600,
    10'd600, 10'd600, 10'd600, 10'd600, 10'd600, 10'd600,
    10'd0, 10'd1023
  };

  typedef struct packed {
    logic [LevelW-1:0] audio;
    logic [LevelW-1:0] peak;
    logic [LevelW-1:0] lit;
    logic [LevelW-1:0] led;
    logic [LevelW-1:0] hue;
  } meter_reading_t;

  // Mirror of the meter state; queues the reading that each sample produces
  class level_meter_tracker;
    int unsigned    ring [Window];
    int unsigned    ring_pos;
    int unsigned    window_sum;
    int unsigned    peak_hold;
    int unsigned    hold_frames;
    int unsigned    hue;
    int unsigned    noise_floor;
    int unsigned    led_count;
    meter_reading_t readings_due [$];
    int unsigned    checked;
    int unsigned    mismatches;

    function new();
      noise_floor = 32'(NoiseReset);
      led_count   = 32'(CountReset);
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgNoise: noise_floor = 32'(data[NoiseW-1:0]);
        CfgCount: led_count = 32'(data[CountW-1:0]);
        default: ;
      endcase
    endfunction

    // Advance the window, level, hue and peak state by one sample request
    function void note_sample(logic [SampleW-1:0] s);
      int unsigned    mean;
      int unsigned    dev;
      int unsigned    lvl;
      int unsigned    level8;
      int unsigned    span;
      meter_reading_t r;
      window_sum = window_sum - ring[ring_pos] + 32'(s);
      ring[ring_pos] = 32'(s);
      ring_pos = (ring_pos + 1) % Window;
      mean = window_sum / Window;
      dev = (s >= mean) ? s - mean : mean - s;
      lvl = (dev > noise_floor) ? dev - noise_floor : 0;
      if (lvl > LevelMax) lvl = LevelMax;
      level8 = lvl * ScaleMax / LevelMax;
      // Beat test uses the peak from before this sample
      if (level8 > peak_hold + BeatMargin) hue = (hue + HueStep) % 256;
      if (level8 > peak_hold) begin
        peak_hold = level8;
        hold_frames = 0;
      end else begin
        if (hold_frames < HoldMax) hold_frames++;
        if (hold_frames > HoldFrames) peak_hold = (peak_hold > DecayStep) ? peak_hold - DecayStep : 0;
      end
      span = (led_count > 0) ? led_count - 1 : 0;
      r.audio = LevelW'(level8);
      r.peak  = LevelW'(peak_hold);
      r.lit   = LevelW'(level8 * led_count / ScaleMax);
      r.led   = LevelW'(peak_hold * span / ScaleMax);
      r.hue   = LevelW'(hue);
      readings_due.push_back(r);
    endfunction

    function void check_result(meter_reading_t got);
      meter_reading_t want;
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("ERROR: result with nothing pending: audio=%0d peak=%0d lit=%0d led=%0d hue=%0d",
                   got.audio, got.peak, got.lit, got.led, got.hue);
        return;
      end
      want = readings_due.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= ReportMax) begin
          $display("ERROR: reading %0d expected audio=%0d peak=%0d lit=%0d led=%0d hue=%0d",
                   checked, want.audio, want.peak, want.lit, want.led, want.hue);
          $display("       got                  audio=%0d peak=%0d lit=%0d led=%0d hue=%0d",
                   got.audio, got.peak, got.lit, got.led, got.hue);
        end
      end
    endfunction

    function int unsigned pending();
      return readings_due.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SampleW-1:0]  sample_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [LevelW-1:0]   audio_level_o;
  logic [LevelW-1:0]   peak_level_o;
  logic [LevelW-1:0]   lit_count_o;
  logic [LevelW-1:0]   peak_led_o;
  logic [LevelW-1:0]   beat_hue_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  level_meter_tracker tracker = new();
  int                 quiet_base = 512;
  int unsigned        samples_sent;
  int unsigned        settings_used;

  audio_level_peak_meter_top #(
    .WINDOW_SIZE(Window)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .audio_level_o(audio_level_o),
    .peak_level_o (peak_level_o),
    .lit_count_o  (lit_count_o),
    .peak_led_o   (peak_led_o),
    .beat_hue_o   (beat_hue_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_result(meter_reading_t'{audio_level_o, peak_level_o, lit_count_o,
                                            peak_led_o, beat_hue_o});
  end

  // Stall the result channel: free stretches, sparse stalls and long stalls
  initial begin
    int mode;
    int len;
    out_stall_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(10, 80);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 2) == 0);
          default: out_stall_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Give up on a hung run
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  // Quiet signal near a drifting base, with spikes, jumps and uniform random samples
  function automatic logic [SampleW-1:0] pick_sample();
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      v = quiet_base + int'($urandom_range(0, 8)) - 4;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v[SampleW-1:0];
    end else if (pick < 60) begin
      return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
    end else if (pick < 75) begin
      quiet_base = $urandom_range(0, 1023);
      return quiet_base[SampleW-1:0];
    end
    return SampleW'($urandom_range(0, 1023));
  endfunction

  // Hold one sample request until it is accepted; enter and leave at negedge
  task automatic send_sample(logic [SampleW-1:0] s);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_sample(s);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      sample_i   <= SampleW'($urandom_range(0, 1023));
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  // Drop valid and wait until every pending reading has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (SettleWait) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_phase(int phase);
    int unsigned sent;
    int          burst;
    sent = 0;
    while (sent < PhaseItems) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sent < PhaseItems) begin
          send_sample(pick_sample());
          sent++;
          // Pause mid-phase until the meter has caught up
          if (phase == 3 && sent == PhaseItems / 2) drain();
        end
      end
      idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
    end
  endtask

  initial begin
    logic [NoiseW-1:0] noise;
    logic [CountW-1:0] count;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    sample_i     = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgNoise;
    cfg_data_i   = '0;
    samples_sent = 0;
    settings_used = 1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed run under reset register values
    for (int i = 0; i < NumDirected; i++) send_sample(DirectedSamples[i]);
    drain();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin noise = 10'd0;    count = 8'd255; end
        1: begin noise = 10'd1023; count = 8'd1;   end
        2: begin noise = 10'd5;    count = 8'd0;   end
        3: begin noise = 10'd300;  count = 8'd128; end
        7: begin noise = NoiseReset; count = CountReset; end
        default: begin
          noise = NoiseW'($urandom_range(0, 200));
          count = CountW'($urandom_range(1, 255));
        end
      endcase
      write_register(CfgNoise, noise);
      // Upper data bits are ignored by the LED count register
      write_register(CfgCount, {2'($urandom_range(0, 3)), count});
      settings_used++;
      run_phase(phase);
      drain();
    end

    $display("Covered %0d samples over %0d register settings, %0d readings compared.",
             samples_sent, settings_used, tracker.checked);
    $display("Settings spanned noise floor 0 to 1023 and LED counts 0, 1 and 255; %0d mismatches.",
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
